@@ hw/rtl/pfa_pkg.sv @@
// Shared types and codes for the paged frame allocator.
package pfa_pkg;

   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_READ  = 2'd2,
      OP_WRITE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_FAULT = 2'd1,
      STAT_OOM   = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_ALLOC_RD,
      S_ALLOC_CHK,
      S_ALLOC_SCAN,
      S_ALLOC_END,
      S_LOOK,
      S_BYTE_OP,
      S_RD_WAIT,
      S_FREE_RD,
      S_FREE_CHK,
      S_RESP
   } state_type;

   typedef struct packed {
      op_type      opcode;
      logic [3:0]  process_id;
      logic [19:0] virtual_address;
      logic [20:0] request_size;
      logic [7:0]  write_byte;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [19:0] granted_address;
      logic [7:0]  read_byte;
   } rsp_type;

endpackage

@@ hw/rtl/pfa_ram.sv @@
// Generic simple dual-port RAM with registered read.
module pfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/paged_frame_allocator_mmu.sv @@
// Paged frame allocator: frame table, break pointers and byte RAM with a sequencer.
// Allocate: checks the break pointer, then on success scans the frame table up to the last frame taken.
// Read/write scans the frame table for the matching page; a miss scans the whole table.
// Free walks the owner's chain, releasing frames until the chain ends or a foreign owner ends the walk.
// One transaction at a time; the result register lets the next request in while a result waits.
// Reset: a clearing pass zeroes all memories; requests stall.
module paged_frame_allocator_mmu #(
   parameter int OFFSET_BITS   = 10,
   parameter int FRAME_COUNT   = 1024,
   parameter int PROCESS_COUNT = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pfa_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pfa_pkg::rsp_type rsp_data
);

   localparam int FW    = $clog2(FRAME_COUNT);
   localparam int NW    = $clog2(FRAME_COUNT + 1);
   localparam int AW    = FW + OFFSET_BITS;
   localparam int BW    = AW + 1;
   localparam int PW    = $clog2(PROCESS_COUNT);
   localparam int FEW   = 4 + FW + NW;
   localparam int SUMW  = (21 > OFFSET_BITS ? 21 : OFFSET_BITS) + 1;
   localparam int PGW   = SUMW - OFFSET_BITS;
   localparam int BYTES = FRAME_COUNT * (2 ** OFFSET_BITS);
   localparam longint unsigned RAM_BYTES = longint'(FRAME_COUNT) << OFFSET_BITS;

   pfa_pkg::state_type  state_ff, state_in;
   pfa_pkg::op_type     op_ff, op_in;
   logic [3:0]          pid_ff, pid_in;
   logic [19:0]         vaddr_ff, vaddr_in;
   logic [7:0]          wdata_ff, wdata_in;
   logic [PGW-1:0]      pages_ff, pages_in;
   logic [BW-1:0]       base_ff, base_in;
   logic [FW:0]         scan_ff, scan_in;
   logic                rvld_ff, rvld_in;
   logic [FW-1:0]       raddr_ff, raddr_in;
   logic [PGW-1:0]      cnt_ff, cnt_in;
   logic [FW-1:0]       prev_ff, prev_in;
   logic [FW-1:0]       prevvp_ff, prevvp_in;
   logic [NW-1:0]       cur_ff, cur_in;
   logic [FEW-1:0]      ent_ff, ent_in;
   logic                fresh_ff, fresh_in;
   logic [FW:0]         steps_ff, steps_in;
   logic [NW-1:0]       free_cnt_ff, free_cnt_in;
   logic [AW-1:0]       clr_ff, clr_in;
   pfa_pkg::status_type status_ff, status_in;
   logic [19:0]         granted_ff, granted_in;
   logic [7:0]          rbyte_ff, rbyte_in;
   logic                rsp_valid_ff, rsp_valid_in;
   pfa_pkg::rsp_type    rsp_ff, rsp_in;

   logic                fr_we;
   logic [FW-1:0]       fr_waddr, fr_raddr;
   logic [FEW-1:0]      fr_wdata, fr_rdata;
   logic                br_we;
   logic [PW-1:0]       br_waddr, br_raddr;
   logic [BW-1:0]       br_wdata, br_rdata;
   logic                by_we;
   logic [AW-1:0]       by_waddr, by_raddr;
   logic [7:0]          by_wdata, by_rdata;

   logic [FEW-1:0]      chk_ent;
   logic [PGW-1:0]      cnt_nx;
   logic [FW-1:0]       base_page;
   logic [PGW-1:0]      pages_calc;
   logic [SUMW-1:0]     size_sum;
   logic                pid_ok, found, match;
   logic [AW-1:0]       pa;
   logic [63:0]         new_break;

   pfa_ram #(.WIDTH(FEW), .DEPTH(FRAME_COUNT)) u_frame_ram (
      .clock  (clock),
      .wr_en  (fr_we),
      .wr_addr(fr_waddr),
      .wr_data(fr_wdata),
      .rd_addr(fr_raddr),
      .rd_data(fr_rdata)
   );

   pfa_ram #(.WIDTH(BW), .DEPTH(PROCESS_COUNT)) u_break_ram (
      .clock  (clock),
      .wr_en  (br_we),
      .wr_addr(br_waddr),
      .wr_data(br_wdata),
      .rd_addr(br_raddr),
      .rd_data(br_rdata)
   );

   pfa_ram #(.WIDTH(8), .DEPTH(BYTES)) u_byte_ram (
      .clock  (clock),
      .wr_en  (by_we),
      .wr_addr(by_waddr),
      .wr_data(by_wdata),
      .rd_addr(by_raddr),
      .rd_data(by_rdata)
   );

   assign size_sum   = SUMW'(req_data.request_size) + SUMW'((longint'(1) << OFFSET_BITS) - 1);
   assign pages_calc = size_sum[SUMW-1:OFFSET_BITS];
   assign pid_ok     = (pid_ff != 4'd0) && (32'(pid_ff) < PROCESS_COUNT);
   assign base_page  = FW'(base_ff >> OFFSET_BITS);
   assign new_break  = 64'(br_rdata) + (64'(pages_ff) << OFFSET_BITS);
   assign found      = rvld_ff && (fr_rdata[FEW-1 -: 4] == 4'd0);
   assign match      = rvld_ff && (fr_rdata[FEW-1 -: 4] == pid_ff)
                       && (32'(fr_rdata[NW +: FW]) == 32'(vaddr_ff[19:OFFSET_BITS]));
   assign cnt_nx     = cnt_ff + PGW'(found);
   assign pa         = {cur_ff[FW-1:0], vaddr_ff[OFFSET_BITS-1:0]};
   assign chk_ent    = fresh_ff ? fr_rdata : ent_ff;
   assign br_raddr   = PW'(pid_ff);
   assign by_raddr   = pa;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pfa_pkg::S_CLEAR;
         clr_ff       <= '0;
         free_cnt_ff  <= NW'(FRAME_COUNT);
         rsp_valid_ff <= 1'b0;
         rvld_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         free_cnt_ff  <= free_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         rvld_ff      <= rvld_in;
      end
      op_ff      <= op_in;
      pid_ff     <= pid_in;
      vaddr_ff   <= vaddr_in;
      wdata_ff   <= wdata_in;
      pages_ff   <= pages_in;
      base_ff    <= base_in;
      scan_ff    <= scan_in;
      raddr_ff   <= raddr_in;
      cnt_ff     <= cnt_in;
      prev_ff    <= prev_in;
      prevvp_ff  <= prevvp_in;
      cur_ff     <= cur_in;
      ent_ff     <= ent_in;
      fresh_ff   <= fresh_in;
      steps_ff   <= steps_in;
      status_ff  <= status_in;
      granted_ff <= granted_in;
      rbyte_ff   <= rbyte_in;
      rsp_ff     <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      pid_in       = pid_ff;
      vaddr_in     = vaddr_ff;
      wdata_in     = wdata_ff;
      pages_in     = pages_ff;
      base_in      = base_ff;
      scan_in      = scan_ff;
      rvld_in      = 1'b0;
      raddr_in     = raddr_ff;
      cnt_in       = cnt_ff;
      prev_in      = prev_ff;
      prevvp_in    = prevvp_ff;
      cur_in       = cur_ff;
      ent_in       = ent_ff;
      fresh_in     = fresh_ff;
      steps_in     = steps_ff;
      free_cnt_in  = free_cnt_ff;
      clr_in       = clr_ff;
      status_in    = status_ff;
      granted_in   = granted_ff;
      rbyte_in     = rbyte_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      req_stall    = 1'b1;
      fr_we        = 1'b0;
      fr_waddr     = prev_ff;
      fr_wdata     = '0;
      fr_raddr     = scan_ff[FW-1:0];
      br_we        = 1'b0;
      br_waddr     = PW'(pid_ff);
      br_wdata     = '0;
      by_we        = 1'b0;
      by_waddr     = pa;
      by_wdata     = wdata_ff;

      case (state_ff)
         pfa_pkg::S_CLEAR: begin
            by_we    = 1'b1;
            by_waddr = clr_ff;
            by_wdata = 8'd0;
            fr_we    = 64'(clr_ff) < 64'(FRAME_COUNT);
            fr_waddr = clr_ff[FW-1:0];
            br_we    = 64'(clr_ff) < 64'(PROCESS_COUNT);
            br_waddr = PW'(clr_ff);
            clr_in   = clr_ff + AW'(1);
            if (64'(clr_ff) == RAM_BYTES - 1) begin
               state_in = pfa_pkg::S_IDLE;
            end
         end
         pfa_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               op_in      = req_data.opcode;
               pid_in     = req_data.process_id;
               vaddr_in   = req_data.virtual_address;
               wdata_in   = req_data.write_byte;
               pages_in   = pages_calc;
               status_in  = pfa_pkg::STAT_OK;
               granted_in = '0;
               rbyte_in   = '0;
               scan_in    = '0;
               cnt_in     = '0;
               if (req_data.opcode == pfa_pkg::OP_ALLOC) begin
                  state_in = pfa_pkg::S_ALLOC_RD;
               end else begin
                  state_in = pfa_pkg::S_LOOK;
               end
            end
         end
         pfa_pkg::S_ALLOC_RD: begin
            state_in = pfa_pkg::S_ALLOC_CHK;
         end
         pfa_pkg::S_ALLOC_CHK: begin
            base_in = br_rdata;
            if (!pid_ok || (64'(free_cnt_ff) < 64'(pages_ff)) || (new_break > RAM_BYTES)) begin
               status_in = pfa_pkg::STAT_OOM;
               state_in  = pfa_pkg::S_RESP;
            end else begin
               granted_in = 20'(br_rdata);
               if (pages_ff == '0) begin
                  state_in = pfa_pkg::S_RESP;
               end else begin
                  br_we    = 1'b1;
                  br_wdata = BW'(new_break);
                  state_in = pfa_pkg::S_ALLOC_SCAN;
               end
            end
         end
         pfa_pkg::S_ALLOC_SCAN: begin
            cnt_in = cnt_nx;
            if (found) begin
               fr_we     = cnt_ff != '0;
               fr_waddr  = prev_ff;
               fr_wdata  = {pid_ff, prevvp_ff, NW'(raddr_ff)};
               prev_in   = raddr_ff;
               prevvp_in = base_page + FW'(cnt_ff);
            end
            if (found && (cnt_nx == pages_ff)) begin
               state_in = pfa_pkg::S_ALLOC_END;
            end else if (64'(scan_ff) < 64'(FRAME_COUNT)) begin
               fr_raddr = scan_ff[FW-1:0];
               raddr_in = scan_ff[FW-1:0];
               rvld_in  = 1'b1;
               scan_in  = scan_ff + (FW+1)'(1);
            end
         end
         pfa_pkg::S_ALLOC_END: begin
            fr_we       = 1'b1;
            fr_waddr    = prev_ff;
            fr_wdata    = {pid_ff, prevvp_ff, NW'(FRAME_COUNT)};
            free_cnt_in = free_cnt_ff - NW'(pages_ff);
            state_in    = pfa_pkg::S_RESP;
         end
         pfa_pkg::S_LOOK: begin
            if (!pid_ok) begin
               status_in = pfa_pkg::STAT_FAULT;
               state_in  = pfa_pkg::S_RESP;
            end else if (match) begin
               cur_in   = NW'(raddr_ff);
               ent_in   = fr_rdata;
               fresh_in = 1'b0;
               steps_in = '0;
               if (op_ff == pfa_pkg::OP_FREE) begin
                  state_in = pfa_pkg::S_FREE_CHK;
               end else begin
                  state_in = pfa_pkg::S_BYTE_OP;
               end
            end else if (64'(scan_ff) < 64'(FRAME_COUNT)) begin
               fr_raddr = scan_ff[FW-1:0];
               raddr_in = scan_ff[FW-1:0];
               rvld_in  = 1'b1;
               scan_in  = scan_ff + (FW+1)'(1);
            end else begin
               status_in = pfa_pkg::STAT_FAULT;
               state_in  = pfa_pkg::S_RESP;
            end
         end
         pfa_pkg::S_BYTE_OP: begin
            if (op_ff == pfa_pkg::OP_WRITE) begin
               by_we    = 1'b1;
               state_in = pfa_pkg::S_RESP;
            end else begin
               state_in = pfa_pkg::S_RD_WAIT;
            end
         end
         pfa_pkg::S_RD_WAIT: begin
            rbyte_in = by_rdata;
            state_in = pfa_pkg::S_RESP;
         end
         pfa_pkg::S_FREE_RD: begin
            fr_raddr = cur_ff[FW-1:0];
            fresh_in = 1'b1;
            if (64'(cur_ff) < 64'(FRAME_COUNT)) begin
               state_in = pfa_pkg::S_FREE_CHK;
            end else begin
               state_in = pfa_pkg::S_RESP;
            end
         end
         pfa_pkg::S_FREE_CHK: begin
            if ((64'(cur_ff) < 64'(FRAME_COUNT)) && (chk_ent[FEW-1 -: 4] == pid_ff)
                && (64'(steps_ff) < 64'(FRAME_COUNT))) begin
               fr_we       = 1'b1;
               fr_waddr    = cur_ff[FW-1:0];
               fr_wdata    = {4'd0, chk_ent[NW +: FW], NW'(FRAME_COUNT)};
               free_cnt_in = free_cnt_ff + NW'(1);
               cur_in      = chk_ent[NW-1:0];
               steps_in    = steps_ff + (FW+1)'(1);
               state_in    = pfa_pkg::S_FREE_RD;
            end else begin
               state_in = pfa_pkg::S_RESP;
            end
         end
         pfa_pkg::S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in           = 1'b1;
               rsp_in.status          = status_ff;
               rsp_in.granted_address = granted_ff;
               rsp_in.read_byte       = rbyte_ff;
               state_in               = pfa_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = pfa_pkg::S_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ tb/tb.sv @@
// Testbench for the paged frame allocator: directed and random requests checked against a model.
`timescale 1ns / 1ps

module tb;

   localparam int  OFFSET_BITS = 10;
   localparam int  FRAME_COUNT = 1024;
   localparam int  PROC_COUNT  = 16;
   localparam int  DRAIN       = 2200;
   localparam longint MEM_BYTES = longint'(FRAME_COUNT) << OFFSET_BITS;
   localparam longint LIMIT    = 12_000_000;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   pfa_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   pfa_pkg::rsp_type rsp_data;

   paged_frame_allocator_mmu i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   logic [3:0]  owner_tbl [FRAME_COUNT];
   logic [9:0]  vpage_tbl [FRAME_COUNT];
   logic [10:0] next_tbl  [FRAME_COUNT];
   longint      brk       [PROC_COUNT];
   int          free_frames;
   logic [7:0]  ram [int];

   pfa_pkg::rsp_type expected_rsps[$];
   int               errors;
   longint           cycles;
   bit               quiet;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic int lookup_frame(logic [3:0] pid, logic [19:0] va);
      if (pid == 0) return -1;
      for (int f = 0; f < FRAME_COUNT; f++)
         if (owner_tbl[f] == pid && vpage_tbl[f] == va[19:OFFSET_BITS]) return f;
      return -1;
   endfunction

   function automatic pfa_pkg::rsp_type predict_rsp(pfa_pkg::req_type rq);
      pfa_pkg::rsp_type r;
      int      f;
      int      nxt;
      int      steps;
      int      idx;
      int      prev;
      longint  pages;
      longint  base;
      r = '0;
      r.status = pfa_pkg::STAT_OK;
      case (rq.opcode)
         pfa_pkg::OP_ALLOC: begin
            pages = (longint'(rq.request_size) + (1 << OFFSET_BITS) - 1) >> OFFSET_BITS;
            if (rq.process_id == 0) begin
               r.status = pfa_pkg::STAT_OOM;
            end else begin
               base = brk[rq.process_id];
               if (free_frames < pages || base + (pages << OFFSET_BITS) > MEM_BYTES) begin
                  r.status = pfa_pkg::STAT_OOM;
               end else begin
                  r.granted_address = base[19:0];
                  brk[rq.process_id] = base + (pages << OFFSET_BITS);
                  idx = 0;
                  prev = 0;
                  for (f = 0; f < FRAME_COUNT && idx < pages; f++) begin
                     if (owner_tbl[f] != 0) continue;
                     owner_tbl[f] = rq.process_id;
                     vpage_tbl[f] = 10'((base >> OFFSET_BITS) + idx);
                     next_tbl[f]  = 11'(FRAME_COUNT);
                     if (idx > 0) next_tbl[prev] = 11'(f);
                     prev = f;
                     free_frames--;
                     idx++;
                  end
               end
            end
         end
         pfa_pkg::OP_FREE: begin
            f = lookup_frame(rq.process_id, rq.virtual_address);
            if (f < 0) begin
               r.status = pfa_pkg::STAT_FAULT;
            end else begin
               steps = 0;
               while (f < FRAME_COUNT && owner_tbl[f] == rq.process_id && steps < FRAME_COUNT) begin
                  nxt = next_tbl[f];
                  owner_tbl[f] = 0;
                  next_tbl[f] = 11'(FRAME_COUNT);
                  free_frames++;
                  f = nxt;
                  steps++;
               end
            end
         end
         default: begin
            f = lookup_frame(rq.process_id, rq.virtual_address);
            if (f < 0) begin
               r.status = pfa_pkg::STAT_FAULT;
            end else begin
               idx = (f << OFFSET_BITS) | rq.virtual_address[OFFSET_BITS-1:0];
               if (rq.opcode == pfa_pkg::OP_READ)
                  r.read_byte = ram.exists(idx) ? ram[idx] : 8'd0;
               else
                  ram[idx] = rq.write_byte;
            end
         end
      endcase
      return r;
   endfunction

   task automatic send_request(pfa_pkg::op_type op, logic [3:0] pid, logic [19:0] va,
                               logic [20:0] size, logic [7:0] wb);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data.opcode = op;
      req_data.process_id = pid;
      req_data.virtual_address = va;
      req_data.request_size = size;
      req_data.write_byte = wb;
      do @(posedge clock); while (req_stall);
      expected_rsps.push_back(predict_rsp(req_data));
      @(negedge clock);
   endtask

   initial begin
      int n;
      rsp_stall = 1'b0;
      forever begin
         n = quiet ? 0 : $urandom_range(0, 18);
         rsp_stall = (n > 0);
         repeat (n) @(negedge clock);
         rsp_stall = 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      pfa_pkg::rsp_type exp_rsp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected result %p", $time, rsp_data);
            errors++;
         end else begin
            exp_rsp = expected_rsps.pop_front();
            if (rsp_data.status !== exp_rsp.status) begin
               $display("%0t: status expected %0d actual %0d", $time, exp_rsp.status,
                        rsp_data.status);
               errors++;
            end
            if (rsp_data.granted_address !== exp_rsp.granted_address) begin
               $display("%0t: granted_address expected %h actual %h", $time,
                        exp_rsp.granted_address, rsp_data.granted_address);
               errors++;
            end
            if (rsp_data.read_byte !== exp_rsp.read_byte) begin
               $display("%0t: read_byte expected %h actual %h", $time, exp_rsp.read_byte,
                        rsp_data.read_byte);
               errors++;
            end
         end
      end
   end

   task automatic test_full_ram();
      send_request(pfa_pkg::OP_ALLOC, 4'd14, 20'd0, 21'd1048576, 8'd0);
      send_request(pfa_pkg::OP_ALLOC, 4'd13, 20'd0, 21'd1, 8'd0);
      send_request(pfa_pkg::OP_WRITE, 4'd14, 20'hFFFFF, 21'd0, 8'hFF);
      send_request(pfa_pkg::OP_READ, 4'd14, 20'hFFFFF, 21'd0, 8'd0);
      send_request(pfa_pkg::OP_FREE, 4'd14, 20'd0, 21'd0, 8'd0);
      send_request(pfa_pkg::OP_ALLOC, 4'd14, 20'd0, 21'd1, 8'd0);
      send_request(pfa_pkg::OP_READ, 4'd14, 20'd5, 21'd0, 8'd0);
   endtask

   task automatic test_reserved_pid();
      send_request(pfa_pkg::OP_ALLOC, 4'd0, 20'd0, 21'd100, 8'd0);
      send_request(pfa_pkg::OP_FREE, 4'd0, 20'd0, 21'd0, 8'd0);
      send_request(pfa_pkg::OP_WRITE, 4'd0, 20'd0, 21'd0, 8'h5A);
      send_request(pfa_pkg::OP_READ, 4'd0, 20'd0, 21'd0, 8'd0);
   endtask

   task automatic test_chain_ops();
      send_request(pfa_pkg::OP_ALLOC, 4'd1, 20'd0, 21'd0, 8'd0);
      send_request(pfa_pkg::OP_ALLOC, 4'd1, 20'd0, 21'd3000, 8'd0);
      send_request(pfa_pkg::OP_ALLOC, 4'd2, 20'd0, 21'd1024, 8'd0);
      send_request(pfa_pkg::OP_WRITE, 4'd1, 20'd2047, 21'd0, 8'hA5);
      send_request(pfa_pkg::OP_WRITE, 4'd2, 20'd0, 21'd0, 8'h3C);
      send_request(pfa_pkg::OP_READ, 4'd1, 20'd2047, 21'd0, 8'd0);
      send_request(pfa_pkg::OP_READ, 4'd1, 20'd5000, 21'd0, 8'd0);
      send_request(pfa_pkg::OP_FREE, 4'd1, 20'd1100, 21'd0, 8'd0);
      send_request(pfa_pkg::OP_READ, 4'd1, 20'd2047, 21'd0, 8'd0);
      send_request(pfa_pkg::OP_READ, 4'd1, 20'd10, 21'd0, 8'd0);
      send_request(pfa_pkg::OP_FREE, 4'd3, 20'd0, 21'd0, 8'd0);
      send_request(pfa_pkg::OP_ALLOC, 4'd15, 20'd0, 21'h1FFFFF, 8'd0);
      send_request(pfa_pkg::OP_READ, 4'd2, 20'd0, 21'd0, 8'd0);
   endtask

   task automatic test_random(int count);
      logic [3:0]  pid;
      logic [19:0] va;
      int          kind;
      for (int i = 0; i < count; i++) begin
         if (i % 60 == 0) quiet = ($urandom_range(0, 3) == 0);
         pid = 4'($urandom_range(1, 15));
         kind = $urandom_range(0, 99);
         va = (brk[pid] > 0) ? 20'($urandom % brk[pid]) : 20'($urandom);
         if (kind < 8) begin
            send_request(pfa_pkg::op_type'($urandom_range(0, 3)), 4'($urandom), 20'($urandom),
                         21'($urandom), 8'($urandom));
         end else if (kind < 35) begin
            send_request(pfa_pkg::OP_ALLOC, pid, 20'($urandom),
                         ($urandom_range(0, 9) == 0) ? 21'($urandom_range(0, 70000))
                                                     : 21'($urandom_range(0, 6000)),
                         8'($urandom));
         end else if (kind < 45) begin
            send_request(pfa_pkg::OP_FREE, pid, va, 21'($urandom), 8'($urandom));
         end else if (kind < 72) begin
            send_request(pfa_pkg::OP_WRITE, pid, va, 21'($urandom), 8'($urandom));
         end else begin
            send_request(pfa_pkg::OP_READ, pid, va, 21'($urandom), 8'($urandom));
         end
      end
      quiet = 1'b0;
   endtask

   initial begin
      for (int f = 0; f < FRAME_COUNT; f++) begin
         owner_tbl[f] = '0;
         vpage_tbl[f] = '0;
         next_tbl[f]  = '0;
      end
      foreach (brk[p]) brk[p] = 0;
      free_frames = FRAME_COUNT;
      errors = 0;
      cycles = 0;
      quiet = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      repeat (7) @(negedge clock);
      reset = 1'b0;
      test_full_ram();
      test_reserved_pid();
      test_chain_ops();
      test_random(556);
      req_valid = 1'b0;
      while (expected_rsps.size() > 0) @(negedge clock);
      repeat (DRAIN) @(negedge clock);
      if (errors == 0 && expected_rsps.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
